// ===== rtl/core/bmhq_pkg.sv =====
// Shared constants and types for the binary max-heap queue.
// No dependencies.
package bmhq_pkg;
    localparam int CAPACITY    = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int ACTION_W    = 3;
    localparam int STATUS_W    = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_POP    = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_FIND   = 3'd3,
        ACT_CLEAR  = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;
endpackage

// ===== rtl/core/bmhq_if.sv =====
// Valid/ready channel interfaces for the heap queue command and result words.
// Depends on bmhq_pkg.
interface bmhq_cmd_if import bmhq_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [ACTION_W-1:0]           action;
    logic signed [VALUE_WIDTH-1:0] item_value;
    modport source (output valid, action, item_value, input ready);
    modport sink   (input valid, action, item_value, output ready);
endinterface

interface bmhq_res_if import bmhq_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [STATUS_W-1:0]           status;
    logic signed [VALUE_WIDTH-1:0] top_value;
    logic [CNT_W-1:0]              element_count;
    logic [ADDR_W-1:0]             found_position;
    modport source (output valid, status, top_value, element_count, found_position, input ready);
    modport sink   (input valid, status, top_value, element_count, found_position, output ready);
endinterface

// ===== rtl/core/binary_max_heap_queue.sv =====
// Binary max-heap priority queue: sequencer around one heap RAM.
// Depends on bmhq_pkg, bmhq_if (bmhq_cmd_if, bmhq_res_if) and bmhq_ram.
//
//   port   dir  word                                         handshake
//   i_cmd  in   action, item_value                           valid/ready
//   o_res  out  status, top_value, element_count, found_pos  valid/ready
//
// One word at a time. Insert climbs level by level toward the root.
// Pop/remove descends level by level, then climbs; each RAM read is
// registered. Find/remove search checks node by node and climbs back
// level by level. Clear and empty cases go straight to FIN.
// Reset clears the state, count and output valid only; heap entries are never read before written.
// A finished result waits in FIN until the output register is free.
module binary_max_heap_queue
    import bmhq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bmhq_cmd_if.sink    i_cmd,
    bmhq_res_if.source  o_res
);
    typedef enum logic [3:0] {
        S_IDLE, S_UP, S_UPW, S_SDL, S_SDLW, S_SDRW,
        S_SRCHK, S_SRW, S_SRADV, S_TKW, S_FIN
    } t_state;

    t_state                        r_state, n_state;
    t_action                       r_act, n_act;
    logic signed [VALUE_WIDTH-1:0] r_v, n_v, r_x, n_x, r_lval, n_lval, r_top, n_top;
    logic [ADDR_W-1:0]             r_pos, n_pos, r_found, n_found;
    logic [CNT_W:0]                r_node, n_node;
    logic [CNT_W-1:0]              r_count, n_count;
    t_status                       r_status, n_status;
    logic                          r_ovalid, n_ovalid;
    t_status                       r_ostatus, n_ostatus;
    logic signed [VALUE_WIDTH-1:0] r_otop, n_otop;
    logic [CNT_W-1:0]              r_ocount, n_ocount;
    logic [ADDR_W-1:0]             r_ofound, n_ofound;

    logic                          we;
    logic [ADDR_W-1:0]             waddr, raddr;
    logic signed [VALUE_WIDTH-1:0] wdata;
    logic [VALUE_WIDTH-1:0]        rdata;
    logic signed [VALUE_WIDTH-1:0] rd_s;
    logic [CNT_W:0]                li, ri, cnt_x;
    logic [ADDR_W-1:0]             parent;
    logic [CNT_W-1:0]              last;

    bmhq_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_heap (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_s   = $signed(rdata);
    assign li     = {1'b0, r_pos, 1'b1};
    assign ri     = li + 1'b1;
    assign cnt_x  = {1'b0, r_count};
    assign parent = (r_pos - 1'b1) >> 1;
    assign last   = r_count - 1'b1;

    assign i_cmd.ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_ovalid;
    assign o_res.status         = r_ostatus;
    assign o_res.top_value      = r_otop;
    assign o_res.element_count  = r_ocount;
    assign o_res.found_position = r_ofound;

    // Accesses are strictly ordered: a write never targets an entry read in
    // the same cycle, so no forwarding is needed.
    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_v       = r_v;
        n_x       = r_x;
        n_lval    = r_lval;
        n_pos     = r_pos;
        n_node    = r_node;
        n_count   = r_count;
        n_status  = r_status;
        n_found   = r_found;
        n_ovalid  = r_ovalid & ~o_res.ready;
        n_ostatus = r_ostatus;
        n_otop    = r_otop;
        n_ocount  = r_ocount;
        n_ofound  = r_ofound;
        we        = 1'b0;
        waddr     = r_pos;
        wdata     = r_x;
        raddr     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_act    = t_action'(i_cmd.action);
                    n_v      = i_cmd.item_value;
                    n_status = ST_OK;
                    n_found  = '0;
                    n_state  = S_FIN;
                    unique case (t_action'(i_cmd.action))
                        ACT_INSERT: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_pos   = r_count[ADDR_W-1:0];
                                n_x     = i_cmd.item_value;
                                n_count = r_count + 1'b1;
                                n_state = S_UP;
                            end
                        end
                        ACT_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = last;
                                if (last != '0) begin
                                    raddr   = last[ADDR_W-1:0];
                                    n_pos   = '0;
                                    n_state = S_TKW;
                                end
                            end
                        end
                        ACT_REMOVE, ACT_FIND: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_node  = '0;
                                n_state = S_SRCHK;
                            end
                        end
                        ACT_CLEAR: n_count = '0;
                        default: ;
                    endcase
                end
            end
            S_UP: begin
                if (r_pos == '0) begin
                    we      = 1'b1;
                    n_state = S_FIN;
                end else begin
                    raddr   = parent;
                    n_state = S_UPW;
                end
            end
            S_UPW: begin
                we = 1'b1;
                if (rd_s < r_x) begin
                    wdata   = rd_s;
                    n_pos   = parent;
                    n_state = S_UP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SDL: begin
                if (li >= cnt_x) begin
                    n_state = S_UP;
                end else begin
                    raddr   = li[ADDR_W-1:0];
                    n_state = S_SDLW;
                end
            end
            S_SDLW: begin
                n_lval = rd_s;
                if (ri < cnt_x) begin
                    raddr   = ri[ADDR_W-1:0];
                    n_state = S_SDRW;
                end else if (r_x < rd_s) begin
                    we      = 1'b1;
                    wdata   = rd_s;
                    n_pos   = li[ADDR_W-1:0];
                    n_state = S_SDL;
                end else begin
                    n_state = S_UP;
                end
            end
            S_SDRW: begin
                if (r_x < r_lval || r_x < rd_s) begin
                    we = 1'b1;
                    if (r_lval > rd_s) begin
                        wdata = r_lval;
                        n_pos = li[ADDR_W-1:0];
                    end else begin
                        wdata = rd_s;
                        n_pos = ri[ADDR_W-1:0];
                    end
                    n_state = S_SDL;
                end else begin
                    n_state = S_UP;
                end
            end
            S_SRCHK: begin
                if (r_node >= cnt_x) begin
                    n_state = S_SRADV;
                end else begin
                    raddr   = r_node[ADDR_W-1:0];
                    n_state = S_SRW;
                end
            end
            S_SRW: begin
                if (rd_s < r_v) begin
                    n_state = S_SRADV;
                end else if (rd_s == r_v) begin
                    if (r_act == ACT_FIND) begin
                        n_found = r_node[ADDR_W-1:0];
                        n_state = S_FIN;
                    end else begin
                        n_count = last;
                        if (r_node[ADDR_W-1:0] == last[ADDR_W-1:0]) begin
                            n_state = S_FIN;
                        end else begin
                            raddr   = last[ADDR_W-1:0];
                            n_pos   = r_node[ADDR_W-1:0];
                            n_state = S_TKW;
                        end
                    end
                end else begin
                    n_node  = {r_node[CNT_W-1:0], 1'b1};
                    n_state = S_SRCHK;
                end
            end
            S_SRADV: begin
                priority if (r_node == '0) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_FIN;
                end else if (!r_node[0]) begin
                    n_node = (r_node - 1'b1) >> 1;
                end else begin
                    n_node  = r_node + 1'b1;
                    n_state = S_SRCHK;
                end
            end
            S_TKW: begin
                n_x     = rd_s;
                n_state = S_SDL;
            end
            S_FIN: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_otop    = (r_count != '0) ? r_top : '0;
                    n_ocount  = r_count;
                    n_ofound  = r_found;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_top = (we && waddr == '0) ? wdata : r_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_act     <= n_act;
        r_v       <= n_v;
        r_x       <= n_x;
        r_lval    <= n_lval;
        r_top     <= n_top;
        r_pos     <= n_pos;
        r_node    <= n_node;
        r_status  <= n_status;
        r_found   <= n_found;
        r_ostatus <= n_ostatus;
        r_otop    <= n_otop;
        r_ocount  <= n_ocount;
        r_ofound  <= n_ofound;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("heap count above capacity");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we && r_state != S_IDLE) |-> ({1'b0, waddr} < r_count))
        else $error("heap write outside stored range");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostatus == ST_FULL) |-> (r_ocount == CNT_W'(CAPACITY)))
        else $error("full status with free space");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostatus == ST_EMPTY) |-> (r_ocount == '0 && r_otop == '0))
        else $error("empty status with stored elements");
endmodule

// ===== rtl/core/bmhq_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
